[rtl/core/psau_pkg.sv]
// Package for the PPU scroll and address unit: operation codes, queue entry
// type, mode codes and the address masks used by the execution stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psau_pkg;

  // Input mode codes
  localparam logic [3:0] MODE_CTRL   = 4'd0;
  localparam logic [3:0] MODE_SCROLL = 4'd1;
  localparam logic [3:0] MODE_ADDR   = 4'd2;
  localparam logic [3:0] MODE_STATUS = 4'd3;
  localparam logic [3:0] MODE_DATA   = 4'd4;
  localparam logic [3:0] MODE_INCX   = 4'd5;
  localparam logic [3:0] MODE_INCY   = 4'd6;
  localparam logic [3:0] MODE_COPYX  = 4'd7;
  localparam logic [3:0] MODE_COPYY  = 4'd8;

  // Classified operation carried from the front to the back
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_CTRL   = 4'd1,
    OP_SCROLL = 4'd2,
    OP_ADDR   = 4'd3,
    OP_STATUS = 4'd4,
    OP_DATA   = 4'd5,
    OP_INCX   = 4'd6,
    OP_INCY   = 4'd7,
    OP_COPYX  = 4'd8,
    OP_COPYY  = 4'd9
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } entry_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [14:0] MASK_KEEP_X  = 15'h7BE0;
  localparam logic [14:0] MASK_HORIZ   = 15'h041F;
  localparam logic [14:0] ROW_STEP     = 15'd32;
  localparam logic [14:0] COL_STEP     = 15'd1;
  localparam logic [4:0]  COARSE_MAX   = 5'd31;
  localparam logic [4:0]  COARSE_Y_END = 5'd29;
  localparam logic [2:0]  FINE_Y_MAX   = 3'd7;
  localparam logic [13:0] TILE_BASE    = 14'h2000;
  localparam logic [13:0] ATTR_BASE    = 14'h23C0;

endpackage

`default_nettype wire

[rtl/core/psau_in_if.sv]
// Request channel into the scroll and address unit: mode and write byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psau_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/psau_out_if.sv]
// Result channel out of the scroll and address unit: fetch addresses and
// scroll state snapshot. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface psau_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] vram_address;
  logic [13:0] tile_address;
  logic [13:0] attribute_address;
  logic [2:0]  attribute_shift;
  logic [2:0]  fine_y;
  logic [2:0]  fine_x;
  logic        write_toggle;

  modport source (output valid, output vram_address, output tile_address,
                  output attribute_address, output attribute_shift,
                  output fine_y, output fine_x, output write_toggle,
                  input ready);
  modport sink   (input valid, input vram_address, input tile_address,
                  input attribute_address, input attribute_shift,
                  input fine_y, input fine_x, input write_toggle,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/ppu_scroll_address_unit.sv]
// PPU scroll and address unit (v/t/x/w registers); top level.
// A request accepted from in_ch passes through a queue slot and then the result register;
// throughput is one request per cycle while out_ch.ready does not stall the result register,
// set by the update of v and t in the back end.
// Reset (rst_n low, synchronous): v, t, fine x, toggle, step and rendering enable
// clear to zero; the queue and the result register empty.
// Depends on psau_pkg, psau_in_if, psau_out_if, psau_front, psau_queue, psau_back.
`timescale 1ns / 1ps
`default_nettype none

module ppu_scroll_address_unit #(
  parameter int QUEUE_DEPTH = psau_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  psau_in_if.sink   in_ch,
  psau_out_if.source out_ch
);

  logic             push_valid, push_ready;
  psau_pkg::entry_t push_entry;
  logic             pop_valid, pop_ready;
  psau_pkg::entry_t pop_entry;

  psau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  psau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  psau_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (pop_valid),
    .entry_ready (pop_ready),
    .entry       (pop_entry),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/psau_front.sv]
// Front end: holds the rendering enable and classifies each request into
// an operation for the queue. Depends on psau_pkg and psau_in_if.
`timescale 1ns / 1ps
`default_nettype none

module psau_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  psau_in_if.sink              in_ch,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output psau_pkg::entry_t     push_entry
);

  logic render_en_r;
  logic render_en_nxt;
  psau_pkg::op_t op;

  always_comb begin
    render_en_nxt = cfg_we ? cfg_wdata : render_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      render_en_r <= 1'b0;
    end else begin
      render_en_r <= render_en_nxt;
    end
  end

  // Rendering-only operations turn into no-ops while rendering is off
  always_comb begin
    unique case (in_ch.mode)
      psau_pkg::MODE_CTRL:   op = psau_pkg::OP_CTRL;
      psau_pkg::MODE_SCROLL: op = psau_pkg::OP_SCROLL;
      psau_pkg::MODE_ADDR:   op = psau_pkg::OP_ADDR;
      psau_pkg::MODE_STATUS: op = psau_pkg::OP_STATUS;
      psau_pkg::MODE_DATA:   op = psau_pkg::OP_DATA;
      psau_pkg::MODE_INCX:   op = render_en_r ? psau_pkg::OP_INCX  : psau_pkg::OP_NONE;
      psau_pkg::MODE_INCY:   op = render_en_r ? psau_pkg::OP_INCY  : psau_pkg::OP_NONE;
      psau_pkg::MODE_COPYX:  op = render_en_r ? psau_pkg::OP_COPYX : psau_pkg::OP_NONE;
      psau_pkg::MODE_COPYY:  op = render_en_r ? psau_pkg::OP_COPYY : psau_pkg::OP_NONE;
      default:               op = psau_pkg::OP_NONE;
    endcase
  end

  assign push_valid       = in_ch.valid;
  assign in_ch.ready      = push_ready;
  assign push_entry.op    = op;
  assign push_entry.value = in_ch.value;

endmodule

`default_nettype wire

[rtl/core/psau_queue.sv]
// Short queue of classified operations between front and back.
// Depends on psau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psau_queue #(
  parameter int DEPTH = psau_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire psau_pkg::entry_t  push_entry,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output psau_pkg::entry_t       pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  psau_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count exceeds depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

[rtl/core/psau_back.sv]
// Back end: owns v, t, fine x, the write toggle and the increment step,
// executes one queued operation per cycle, unless out_ch stalls, into the result register.
// Depends on psau_pkg and psau_out_if.
`timescale 1ns / 1ps
`default_nettype none

module psau_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              entry_valid,
  output logic                   entry_ready,
  input  wire psau_pkg::entry_t  entry,
  psau_out_if.source             out_ch
);

  logic [14:0] v_r, v_nxt;
  logic [14:0] t_r, t_nxt;
  logic [2:0]  fx_r, fx_nxt;
  logic        w_r, w_nxt;
  logic        step_r, step_nxt;
  logic [14:0] snap;
  logic [4:0]  cy;
  logic        advance, pop;
  logic [7:0]  val;

  logic        out_valid_r;
  logic [13:0] vram_r, tile_r, attr_r;
  logic [2:0]  shift_r, fine_y_r, fine_x_r;
  logic        toggle_r;

  assign val         = entry.value;
  assign advance     = !out_valid_r || out_ch.ready;
  assign entry_ready = advance;
  assign pop         = entry_valid && advance;

  always_comb begin
    v_nxt    = v_r;
    t_nxt    = t_r;
    fx_nxt   = fx_r;
    w_nxt    = w_r;
    step_nxt = step_r;
    cy       = v_r[9:5];
    unique case (entry.op)
      psau_pkg::OP_CTRL: begin
        t_nxt[11:10] = val[1:0];
        step_nxt     = val[2];
      end
      psau_pkg::OP_SCROLL: begin
        if (!w_r) begin
          t_nxt[4:0] = val[7:3];
          fx_nxt     = val[2:0];
          w_nxt      = 1'b1;
        end else begin
          t_nxt[14:12] = val[2:0];
          t_nxt[9:5]   = val[7:3];
          w_nxt        = 1'b0;
        end
      end
      psau_pkg::OP_ADDR: begin
        if (!w_r) begin
          t_nxt[14]   = 1'b0;
          t_nxt[13:8] = val[5:0];
          w_nxt       = 1'b1;
        end else begin
          t_nxt[7:0] = val;
          v_nxt      = {t_r[14:8], val};
          w_nxt      = 1'b0;
        end
      end
      psau_pkg::OP_STATUS: begin
        w_nxt = 1'b0;
      end
      psau_pkg::OP_DATA: begin
        v_nxt = v_r + (step_r ? psau_pkg::ROW_STEP : psau_pkg::COL_STEP);
      end
      psau_pkg::OP_INCX: begin
        if (v_r[4:0] == psau_pkg::COARSE_MAX) begin
          v_nxt[4:0] = '0;
          v_nxt[10]  = ~v_r[10];
        end else begin
          v_nxt[4:0] = v_r[4:0] + 1'b1;
        end
      end
      psau_pkg::OP_INCY: begin
        if (v_r[14:12] != psau_pkg::FINE_Y_MAX) begin
          v_nxt[14:12] = v_r[14:12] + 1'b1;
        end else begin
          v_nxt[14:12] = '0;
          // last visible row flips the vertical nametable; row 31 wraps silently
          if (v_r[9:5] == psau_pkg::COARSE_Y_END) begin
            cy        = '0;
            v_nxt[11] = ~v_r[11];
          end else if (v_r[9:5] == psau_pkg::COARSE_MAX) begin
            cy = '0;
          end else begin
            cy = v_r[9:5] + 1'b1;
          end
          v_nxt[9:5] = cy;
        end
      end
      psau_pkg::OP_COPYX: begin
        v_nxt = (v_r & psau_pkg::MASK_KEEP_X) | (t_r & psau_pkg::MASK_HORIZ);
      end
      psau_pkg::OP_COPYY: begin
        v_nxt = (v_r & psau_pkg::MASK_HORIZ) | (t_r & psau_pkg::MASK_KEEP_X);
      end
      psau_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
    // data access reports v before the increment
    snap = (entry.op == psau_pkg::OP_DATA) ? v_r : v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      t_r         <= '0;
      fx_r        <= '0;
      w_r         <= 1'b0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        v_r    <= v_nxt;
        t_r    <= t_nxt;
        fx_r   <= fx_nxt;
        w_r    <= w_nxt;
        step_r <= step_nxt;
      end
      if (advance) begin
        out_valid_r <= entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      vram_r   <= snap[13:0];
      tile_r   <= psau_pkg::TILE_BASE | {2'b00, snap[11:0]};
      attr_r   <= psau_pkg::ATTR_BASE | {2'b00, snap[11:10], 10'd0}
                  | {8'd0, snap[9:7], 3'd0} | {11'd0, snap[4:2]};
      shift_r  <= {snap[6], snap[1], 1'b0};
      fine_y_r <= snap[14:12];
      fine_x_r <= fx_nxt;
      toggle_r <= w_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.vram_address      = vram_r;
  assign out_ch.tile_address      = tile_r;
  assign out_ch.attribute_address = attr_r;
  assign out_ch.attribute_shift   = shift_r;
  assign out_ch.fine_y            = fine_y_r;
  assign out_ch.fine_x            = fine_x_r;
  assign out_ch.write_toggle      = toggle_r;

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && entry.op == psau_pkg::OP_STATUS) |=> (!out_ch.write_toggle && !w_r))
    else $error("status read left the write toggle set");

  a_data_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && entry.op == psau_pkg::OP_DATA) |=> (out_ch.vram_address == $past(v_r[13:0])))
    else $error("data access reported the incremented address");

  a_none_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && entry.op == psau_pkg::OP_NONE) |=> ($stable(v_r) && $stable(t_r)))
    else $error("no-op changed the address registers");

endmodule

`default_nettype wire
